// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the cipher RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold on every clock edge out of reset.
`define ACSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("acsc assertion failed");
// Same-cycle implication.
`define ACSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acsc implication failed");
// Next-cycle implication.
`define ACSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acsc next-cycle check failed");
`else
`define ACSC_ASSERT(lbl, prop)
`define ACSC_ASSERT_IMP(lbl, ante, cons)
`define ACSC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/acsc_pkg.sv =====
// Shared constants, types and round functions of the ARX counter stream cipher.
`timescale 1ns / 1ps
package acsc_pkg;

    // Number of double rounds applied to each block.
    localparam int DOUBLE_ROUNDS = 10;
    // Half quarter-round steps: two per column round, two per diagonal round.
    localparam int STEP_COUNT    = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(STEP_COUNT);

    localparam int NUM_REGS      = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int BLK_WORDS     = 8;
    localparam int BLK_IDX_W     = 3;
    localparam int STATE_WORDS   = 16;
    localparam int POS_W         = 6;

    typedef logic [31:0] word_t;
    typedef logic [63:0] dword_t;

    // Four words of one quarter-round.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   reload;
        logic                   start;
        logic                   round_en;
        logic [STEP_W-1:0]      step;
        logic                   finish;
        logic                   emit;
        logic                   emit_direct;
        logic                   inc_en;
        logic [BLK_IDX_W-1:0]   inc_idx;
        logic                   carry_in;
        logic [POS_W-1:0]       pos;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic inc_carry;
    } status_t;

    // One half of a quarter-round: rotations 16/12 in the first half, 8/7 in the second.
    function automatic quad_t qr_half(input word_t a, input word_t b, input word_t c,
                                      input word_t d, input logic second);
        quad_t q;
        word_t a1;
        word_t c1;
        word_t dx;
        word_t bx;
        a1 = a + b;
        dx = d ^ a1;
        if (second)
            dx = {dx[23:0], dx[31:24]};
        else
            dx = {dx[15:0], dx[31:16]};
        c1 = c + dx;
        bx = b ^ c1;
        if (second)
            bx = {bx[24:0], bx[31:25]};
        else
            bx = {bx[19:0], bx[31:20]};
        q.a = a1;
        q.b = bx;
        q.c = c1;
        q.d = dx;
        return q;
    endfunction

    // Reverse the byte order of a 64-bit word.
    function automatic dword_t byteswap64(input dword_t x);
        dword_t y;
        for (int i = 0; i < 8; i++) begin
            y[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return y;
    endfunction

endpackage

// ===== rtl/core/acsc_datapath.sv =====
// Datapath: configuration, counter block, round state, keystream and result byte.
`timescale 1ns / 1ps
module acsc_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [acsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  acsc_pkg::dword_t                 cfg_data,
    input  logic [7:0]                       data_byte,
    input  acsc_pkg::cmd_t                   cmd,
    output acsc_pkg::status_t                status,
    output logic [7:0]                       result_byte
);

    acsc_pkg::dword_t cfg_reg     [acsc_pkg::NUM_REGS];
    acsc_pkg::dword_t counter_reg [acsc_pkg::BLK_WORDS];
    acsc_pkg::dword_t counter_next[acsc_pkg::BLK_WORDS];
    acsc_pkg::dword_t ks_reg      [acsc_pkg::BLK_WORDS];
    acsc_pkg::dword_t ks_fresh    [acsc_pkg::BLK_WORDS];
    acsc_pkg::dword_t block_src   [acsc_pkg::BLK_WORDS];
    acsc_pkg::word_t  work_reg    [acsc_pkg::STATE_WORDS];
    acsc_pkg::word_t  work_next   [acsc_pkg::STATE_WORDS];
    acsc_pkg::word_t  col_w       [acsc_pkg::STATE_WORDS];
    acsc_pkg::word_t  diag_w      [acsc_pkg::STATE_WORDS];
    logic [7:0]       data_reg;
    logic [7:0]       result_reg;
    logic [7:0]       ks_byte;
    logic [7:0]       src_byte;
    logic [511:0]     ks_flat;
    acsc_pkg::dword_t inc_word;
    acsc_pkg::dword_t inc_sum;

    // Block source: counter block, or key, nonce and zeros on a reload.
    always_comb
    begin
        for (int i = 0; i < acsc_pkg::BLK_WORDS; i++) begin
            if (!cmd.reload)
                block_src[i] = counter_reg[i];
            else if (i < acsc_pkg::NUM_REGS)
                block_src[i] = cfg_reg[i];
            else
                block_src[i] = '0;
        end
    end

    // Column and diagonal half-steps over four independent quarter-rounds.
    always_comb
    begin
        acsc_pkg::quad_t qc;
        acsc_pkg::quad_t qd;
        col_w  = work_reg;
        diag_w = work_reg;
        for (int j = 0; j < 4; j++) begin
            qc = acsc_pkg::qr_half(work_reg[j], work_reg[4 + j], work_reg[8 + j],
                                   work_reg[12 + j], cmd.step[0]);
            col_w[j]      = qc.a;
            col_w[4 + j]  = qc.b;
            col_w[8 + j]  = qc.c;
            col_w[12 + j] = qc.d;
            qd = acsc_pkg::qr_half(work_reg[j], work_reg[4 + ((j + 1) & 3)],
                                   work_reg[8 + ((j + 2) & 3)],
                                   work_reg[12 + ((j + 3) & 3)], cmd.step[0]);
            diag_w[j]                  = qd.a;
            diag_w[4 + ((j + 1) & 3)]  = qd.b;
            diag_w[8 + ((j + 2) & 3)]  = qd.c;
            diag_w[12 + ((j + 3) & 3)] = qd.d;
        end
    end

    // Round state update: load on start, one half-step per round cycle.
    always_comb
    begin
        work_next = work_reg;
        if (cmd.start) begin
            for (int j = 0; j < acsc_pkg::STATE_WORDS; j++) begin
                if ((j & 1) != 0)
                    work_next[j] = block_src[j >> 1][63:32];
                else
                    work_next[j] = block_src[j >> 1][31:0];
            end
        end else if (cmd.round_en) begin
            if (cmd.step[1])
                work_next = diag_w;
            else
                work_next = col_w;
        end
    end

    // Fresh keystream is the permuted block xored with the unpermuted one.
    always_comb
    begin
        for (int i = 0; i < acsc_pkg::BLK_WORDS; i++) begin
            ks_fresh[i] = {work_reg[2*i + 1], work_reg[2*i]} ^ counter_reg[i];
            ks_flat[64*i +: 64] = cmd.finish ? ks_fresh[i] : ks_reg[i];
        end
    end

    assign ks_byte  = ks_flat[{cmd.pos, 3'b000} +: 8];
    assign src_byte = cmd.emit_direct ? data_byte : data_reg;

    // Big-endian counter increment, one 64-bit word per cycle.
    assign inc_word         = counter_reg[cmd.inc_idx];
    assign inc_sum          = acsc_pkg::byteswap64(acsc_pkg::byteswap64(inc_word)
                                                   + {63'd0, cmd.carry_in});
    assign status.inc_carry = cmd.carry_in & (&inc_word);

    always_comb
    begin
        counter_next = counter_reg;
        if (cmd.start)
            counter_next = block_src;
        else if (cmd.inc_en)
            counter_next[cmd.inc_idx] = inc_sum;
    end

    // Control-visible state: configuration and counter block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < acsc_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
            for (int i = 0; i < acsc_pkg::BLK_WORDS; i++) begin
                counter_reg[i] <= '0;
            end
        end else begin
            if (cfg_we && (cfg_index < acsc_pkg::CFG_IDX_W'(acsc_pkg::NUM_REGS)))
                cfg_reg[cfg_index] <= cfg_data;
            counter_reg <= counter_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.start)
            data_reg <= data_byte;
        if (cmd.finish)
            ks_reg <= ks_fresh;
        if (cmd.emit)
            result_reg <= src_byte ^ ks_byte;
    end

    assign result_byte = result_reg;

endmodule

// ===== rtl/core/acsc_ctrl.sv =====
// Controller: handshakes, byte position, round sequencing and counter increment sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acsc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                first_byte,
    output logic                out_valid,
    input  logic                out_stall,
    input  acsc_pkg::status_t   status,
    output acsc_pkg::cmd_t      cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ROUND  = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;
    localparam logic [1:0] S_INC    = 2'd3;

    localparam logic [acsc_pkg::STEP_W-1:0] STEP_LAST =
        acsc_pkg::STEP_W'(acsc_pkg::STEP_COUNT - 1);
    localparam logic [acsc_pkg::POS_W-1:0] POS_LAST = '1;
    localparam logic [acsc_pkg::BLK_IDX_W-1:0] IDX_LAST =
        acsc_pkg::BLK_IDX_W'(acsc_pkg::BLK_WORDS - 1);

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [acsc_pkg::STEP_W-1:0]     step_reg;
    logic [acsc_pkg::STEP_W-1:0]     step_next;
    logic [acsc_pkg::POS_W-1:0]      pos_reg;
    logic [acsc_pkg::POS_W-1:0]      pos_next;
    logic [acsc_pkg::BLK_IDX_W-1:0]  inc_idx_reg;
    logic [acsc_pkg::BLK_IDX_W-1:0]  inc_idx_next;
    logic                            ready_reg;
    logic                            ready_next;
    logic                            carry_reg;
    logic                            carry_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_free;
    logic                            accept;

    // The output register is free when empty or when its beat leaves now.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    // Next-state and command logic.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        inc_idx_next   = inc_idx_reg;
        ready_next     = ready_reg;
        carry_next     = carry_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd             = '0;
        cmd.step        = step_reg;
        cmd.pos         = pos_reg;
        cmd.inc_idx     = inc_idx_reg;
        cmd.carry_in    = carry_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if (ready_reg && !first_byte) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_direct = 1'b1;
                        out_valid_next  = 1'b1;
                        pos_next        = pos_reg + acsc_pkg::POS_W'(1);
                        if (pos_reg == POS_LAST) begin
                            ready_next   = 1'b0;
                            carry_next   = 1'b1;
                            inc_idx_next = IDX_LAST;
                            state_next   = S_INC;
                        end
                    end else begin
                        cmd.start  = 1'b1;
                        cmd.reload = first_byte;
                        if (first_byte) begin
                            pos_next   = '0;
                            ready_next = 1'b0;
                        end
                        step_next  = '0;
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                step_next    = step_reg + acsc_pkg::STEP_W'(1);
                if (step_reg == STEP_LAST)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free) begin
                    cmd.finish     = 1'b1;
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    ready_next     = 1'b1;
                    pos_next       = pos_reg + acsc_pkg::POS_W'(1);
                    state_next     = S_IDLE;
                    if (pos_reg == POS_LAST) begin
                        ready_next   = 1'b0;
                        carry_next   = 1'b1;
                        inc_idx_next = IDX_LAST;
                        state_next   = S_INC;
                    end
                end
            end
            S_INC:
            begin
                cmd.inc_en   = 1'b1;
                carry_next   = status.inc_carry;
                inc_idx_next = inc_idx_reg - acsc_pkg::BLK_IDX_W'(1);
                if (inc_idx_reg == '0)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            pos_reg       <= '0;
            inc_idx_reg   <= '0;
            ready_reg     <= 1'b0;
            carry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            inc_idx_reg   <= inc_idx_next;
            ready_reg     <= ready_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result beat appears only from a direct emit or at the end of a block computation.
    `ACSC_ASSERT_IMP(a_result_source, $rose(out_valid_reg), $past(state_reg) == S_IDLE || $past(state_reg) == S_FINISH)
    // The increment sweep starts at the last word, after the position wrapped.
    `ACSC_ASSERT_IMP(a_inc_entry, state_reg == S_INC && $past(state_reg) != S_INC, pos_reg == '0 && !ready_reg && inc_idx_reg == IDX_LAST)
    // No keystream is marked valid while the rounds are running.
    `ACSC_ASSERT(a_round_not_ready, state_reg != S_ROUND || !ready_reg)
    // A held result is not dropped.
    `ACSC_ASSERT_NXT(a_hold_result, out_valid_reg && out_stall, out_valid_reg)

endmodule

// ===== rtl/core/arx_counter_stream_cipher_unit.sv =====
// Top level of the ARX counter-mode byte stream cipher.
`timescale 1ns / 1ps
// A byte whose keystream block is ready gives its result in the cycle after its beat. A byte
// that needs a new block (first byte, or first after a wrap) waits through the round states
// and the finish state, which holds while the output register is occupied. Throughput: one
// byte per cycle within a block while the output is not stalled; after every 64th byte the
// 512-bit counter is incremented one 64-bit word per cycle. Reset clears the registers,
// counter block and position; the keystream register is recomputed before it is ever read.
module arx_counter_stream_cipher_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [acsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             first_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       result_byte
);

    acsc_pkg::cmd_t    cmd;
    acsc_pkg::status_t status;

    // Sequencer and handshake control.
    acsc_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .first_byte (first_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Rounds, counter and keystream storage.
    acsc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .result_byte (result_byte)
    );

endmodule

// ===== dv/arx_stream_checker.sv =====
// Scoreboard for the ARX counter stream cipher: keystream prediction and result-byte compare.
`timescale 1ns / 1ps
module arx_stream_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [acsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             first_byte,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [7:0]                       result_byte,
    output int                               errors,
    output int                               pending
);
    import acsc_pkg::*;

    // Shadow copy of the key and nonce registers.
    dword_t       key_nonce [NUM_REGS];
    // Counter block and its keystream, byte b at bits 8*b+7..8*b.
    logic [511:0] ctr_blk;
    logic [511:0] ks_blk;
    logic [5:0]   ks_pos;
    logic         ks_valid;
    // Result bytes predicted but not yet seen on the output channel.
    logic [7:0]   cipher_bytes [$];
    logic [7:0]   want;

    function automatic word_t rotl32(input word_t x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // One full quarter-round on four words.
    function automatic quad_t quarter_round(input word_t a, input word_t b,
                                            input word_t c, input word_t d);
        quad_t q;
        a = a + b; d = rotl32(d ^ a, 16);
        c = c + d; b = rotl32(b ^ c, 12);
        a = a + b; d = rotl32(d ^ a, 8);
        c = c + d; b = rotl32(b ^ c, 7);
        q.a = a;
        q.b = b;
        q.c = c;
        q.d = d;
        return q;
    endfunction

    // Permute the block and fold the original back in.
    function automatic logic [511:0] block_keystream(input logic [511:0] blk);
        word_t        w [16];
        quad_t        q;
        logic [511:0] ks;
        int           ia;
        int           ib;
        int           ic;
        int           id;
        for (int j = 0; j < 16; j++)
        begin
            w[j] = blk[32*j +: 32];
        end
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            // Steps 0-3 are the columns, steps 4-7 the diagonals.
            for (int h = 0; h < 8; h++)
            begin
                ia = h % 4;
                ib = 4 + ((h + h / 4) % 4);
                ic = 8 + ((h + 2 * (h / 4)) % 4);
                id = 12 + ((h + 3 * (h / 4)) % 4);
                q = quarter_round(w[ia], w[ib], w[ic], w[id]);
                w[ia] = q.a;
                w[ib] = q.b;
                w[ic] = q.c;
                w[id] = q.d;
            end
        end
        for (int j = 0; j < 16; j++)
        begin
            ks[32*j +: 32] = w[j] ^ blk[32*j +: 32];
        end
        return ks;
    endfunction

    function automatic logic [511:0] reverse_bytes(input logic [511:0] x);
        logic [511:0] y;
        for (int b = 0; b < 64; b++)
        begin
            y[8*b +: 8] = x[8*(63-b) +: 8];
        end
        return y;
    endfunction

    // Big-endian increment with byte 63 least significant; wraps at 2^512.
    function automatic logic [511:0] next_counter(input logic [511:0] blk);
        return reverse_bytes(reverse_bytes(blk) + 512'd1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        errors = errors + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                key_nonce[i] = '0;
            ctr_blk  = '0;
            ks_blk   = '0;
            ks_pos   = '0;
            ks_valid = 1'b0;
            cipher_bytes.delete();
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            // Register writes outside the list are dropped.
            if (cfg_we && cfg_index < NUM_REGS)
                key_nonce[cfg_index] = cfg_data;

            // Result beat: compare against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (cipher_bytes.size() == 0)
                    report_mismatch($sformatf("result byte %02h with nothing pending",
                                              result_byte));
                else
                begin
                    want = cipher_bytes.pop_front();
                    if (result_byte !== want)
                        report_mismatch($sformatf("result_byte %02h, predicted %02h",
                                                  result_byte, want));
                end
            end

            // Input beat: advance the cipher state and predict its byte.
            if (in_valid && !in_stall)
            begin
                if (first_byte)
                begin
                    ctr_blk = '0;
                    for (int i = 0; i < NUM_REGS; i++)
                        ctr_blk[64*i +: 64] = key_nonce[i];
                    ks_pos   = '0;
                    ks_valid = 1'b0;
                end
                if (!ks_valid)
                begin
                    ks_blk   = block_keystream(ctr_blk);
                    ks_valid = 1'b1;
                end
                cipher_bytes.push_back(data_byte ^ ks_blk[8*ks_pos +: 8]);
                ks_pos = ks_pos + 6'd1;
                if (ks_pos == 6'd0)
                begin
                    ctr_blk  = next_counter(ctr_blk);
                    ks_valid = 1'b0;
                end
            end
            pending = cipher_bytes.size();
        end
    end

endmodule

// ===== dv/arx_counter_stream_cipher_unit_test.sv =====
// Stimulus and verdict for the ARX counter stream cipher unit, checked by arx_stream_checker.
`timescale 1ns / 1ps
module arx_counter_stream_cipher_unit_test;
    import acsc_pkg::*;

    localparam int REG_KEY_WORD_0 = 0;
    localparam int REG_NONCE_HIGH = 5;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 64;

    // Key and nonce patterns for program_keys.
    localparam int KEYS_RANDOM    = 0;
    localparam int KEYS_ZERO      = 1;
    localparam int KEYS_ONES      = 2;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [63:0]           cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            data_byte;
    logic                  first_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            result_byte;
    int                    errors;
    int                    pending;

    int                    idle_pct;
    int                    stall_pct;
    int                    hold_left;
    int                    cycle_count;
    int                    bytes_sent;

    arx_counter_stream_cipher_unit u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_byte (result_byte)
    );

    arx_stream_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_byte (result_byte),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL arx_counter_stream_cipher_unit");
            $finish;
        end
    end

    // Result side: a long hold-off when requested, otherwise random stalls.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one beat after a random idle gap and wait until it is taken.
    task automatic send_beat(input logic [7:0] value, input logic reload);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        first_byte <= reload;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // A message of random bytes, opened by a reload unless it continues; rare reloads inside.
    task automatic send_stream(input int len, input logic reload);
        for (int k = 0; k < len; k++)
        begin
            send_beat(8'($urandom_range(255)),
                      (k == 0 && reload) || $urandom_range(199) == 0);
        end
    endtask

    // Let every predicted byte come back, then give the counter sweep time to finish.
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    // Program the key and nonce with random, all-zero or all-one words.
    task automatic program_keys(input int kind, input logic stray_write);
        logic [63:0] value;
        for (int i = REG_KEY_WORD_0; i <= REG_NONCE_HIGH; i++)
        begin
            case (kind)
                KEYS_ZERO: value = '0;
                KEYS_ONES: value = '1;
                default:   value = {$urandom, $urandom};
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= value;
            @(negedge clk);
        end
        // Indexes past the register list must leave the registers alone.
        if (stray_write)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(NUM_REGS + $urandom_range(1));
            cfg_data  <= {$urandom, $urandom};
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int len;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        data_byte   = '0;
        first_byte  = 1'b0;
        out_stall   = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_left   = 0;
        cycle_count = 0;
        bytes_sent  = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Bytes before any reload run on the all-zero counter block.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hA5, 1'b0);
        drain();

        // New keys do not touch the running stream until the next reload.
        program_keys(KEYS_ONES, 1'b1);
        send_beat(8'h5A, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h81, 1'b0);
        // Back-to-back reloads.
        send_beat(8'hFF, 1'b1);
        send_beat(8'h7E, 1'b1);
        drain();
        program_keys(KEYS_ZERO, 1'b1);
        send_beat(8'h3C, 1'b1);
        send_beat(8'hC3, 1'b0);
        drain();

        // Pressure: hold the result side off while bytes keep coming.
        program_keys(KEYS_RANDOM, 1'b0);
        hold_left = 400;
        send_stream(150, 1'b1);
        drain();

        // Random messages under each idle and stall pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 62; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            program_keys(phase == 3 ? KEYS_ONES : KEYS_RANDOM, $urandom_range(2) == 0);
            while (bytes_sent < 160 + 275 * (phase + 1))
            begin
                if ($urandom_range(7) == 0)
                    len = $urandom_range(300, 130);
                else
                    len = $urandom_range(130, 1);
                send_stream(len, $urandom_range(9) != 0);
            end
            drain();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("PASS arx_counter_stream_cipher_unit");
        else
            $display("FAIL arx_counter_stream_cipher_unit");
        $finish;
    end

endmodule
